### rtl/bdpf_pkg.sv
// ----------------------------------------------------------------------------
// bdpf_pkg: shared types and constants of the boot data packet framer
// Command format passed from the front end to the byte serializer.
// ----------------------------------------------------------------------------
package bdpf_pkg;

    localparam int MAX_WORDS    = 256;
    localparam int CNT_W        = 9;
    localparam int ADDR_W       = 32;
    localparam int WORD_W       = 32;
    localparam int BYTE_W       = 8;
    localparam int CSUM_W       = 11;   // six bytes summed
    localparam int SUM_W        = 32;
    localparam int LEN_HI_SHIFT = 10;

    localparam int HDR_BYTES    = 10;
    localparam int DAT_BYTES    = 4;
    localparam int TRL_BYTES    = 4;
    localparam int STEP_W       = $clog2(HDR_BYTES);

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h30;
    localparam logic [BYTE_W-1:0] TYPE_BYTE = 8'h01;
    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hFF;

    // slave tdata layout, lowest field first
    localparam int S_ADDR_LO  = 0;
    localparam int S_CNT_LO   = S_ADDR_LO + ADDR_W;
    localparam int S_WORD_LO  = S_CNT_LO + CNT_W;
    localparam int S_FIELDS_W = S_WORD_LO + WORD_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

    // input command codes (tuser)
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    typedef enum logic {
        K_HDR = 1'b0,
        K_DAT = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic                trail;    // trailer follows this entry
        logic [WORD_W-1:0]   payload;  // address on header, data word on data
        logic [CNT_W-1:0]    cnt;      // saturated word count
        logic [CSUM_W-1:0]   csum;     // header checksum
    } t_cmd;

endpackage

### rtl/bdpf_front.sv
// ----------------------------------------------------------------------------
// bdpf_front: input classifier
// Tracks the open packet, drops stray data beats, builds queue commands.
// ----------------------------------------------------------------------------
module bdpf_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [bdpf_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                        i_s_tuser,
    input  logic                        i_q_full,
    output logic                        o_q_push,
    output bdpf_pkg::t_cmd              o_q_cmd
);
    import bdpf_pkg::*;

    logic [CNT_W-1:0]  r_words_left, n_words_left;
    logic              r_open, n_open;

    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  cnt_in, cnt_sat;
    logic [WORD_W-1:0] word;
    logic [BYTE_W-1:0] len_hi, len_lo;
    logic [CSUM_W-1:0] csum;
    logic              accept, is_start, data_ok;

    assign addr   = i_s_tdata[S_ADDR_LO +: ADDR_W];
    assign cnt_in = i_s_tdata[S_CNT_LO +: CNT_W];
    assign word   = i_s_tdata[S_WORD_LO +: WORD_W];

    assign o_s_tready = !i_q_full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign is_start   = (i_s_tuser == CMD_START);
    assign data_ok    = r_open && (r_words_left != '0);

    assign cnt_sat = (cnt_in > CNT_W'(MAX_WORDS)) ? CNT_W'(MAX_WORDS) : cnt_in;
    assign len_hi  = BYTE_W'((32'(cnt_sat) >> LEN_HI_SHIFT) & 32'(BYTE_MASK));
    assign len_lo  = cnt_sat[BYTE_W-1:0];
    assign csum    = CSUM_W'(len_hi) + CSUM_W'(len_lo)
                   + CSUM_W'(addr[15:8]) + CSUM_W'(addr[7:0])
                   + CSUM_W'(addr[31:24]) + CSUM_W'(addr[23:16]);

    always_comb begin
        n_words_left = r_words_left;
        n_open       = r_open;
        o_q_push     = 1'b0;
        o_q_cmd      = '0;
        if (accept) begin
            if (is_start) begin
                o_q_push        = 1'b1;
                o_q_cmd.kind    = K_HDR;
                o_q_cmd.trail   = (cnt_sat == '0);
                o_q_cmd.payload = addr;
                o_q_cmd.cnt     = cnt_sat;
                o_q_cmd.csum    = csum;
                n_words_left    = cnt_sat;
                n_open          = (cnt_sat != '0);
            end else if (data_ok) begin
                o_q_push        = 1'b1;
                o_q_cmd.kind    = K_DAT;
                o_q_cmd.trail   = (r_words_left == CNT_W'(1));
                o_q_cmd.payload = word;
                n_words_left    = r_words_left - CNT_W'(1);
                n_open          = (r_words_left != CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_left <= '0;
            r_open       <= 1'b0;
        end else begin
            r_words_left <= n_words_left;
            r_open       <= n_open;
        end
    end

    a_open_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open == (r_words_left != '0))
        else $error("open flag out of step with word count");

endmodule

### rtl/bdpf_queue.sv
// ----------------------------------------------------------------------------
// bdpf_queue: two-entry command queue
// Decouples the classifier from the byte serializer.
// ----------------------------------------------------------------------------
module bdpf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bdpf_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output bdpf_pkg::t_cmd o_cmd
);
    import bdpf_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= !r_wptr;
            if (i_pop)  r_rptr <= !r_rptr;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full command queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("pop from empty command queue");

endmodule

### rtl/bdpf_back.sv
// ----------------------------------------------------------------------------
// bdpf_back: byte serializer
// Emits header, data and trailer bytes; keeps the running byte sum.
// ----------------------------------------------------------------------------
module bdpf_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  bdpf_pkg::t_cmd              i_q_cmd,
    output logic                        o_q_pop,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [bdpf_pkg::BYTE_W-1:0] o_m_tdata,
    output logic                        o_m_tlast,
    output logic                        o_m_tuser
);
    import bdpf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HDR  = 4'b0010,
        S_DAT  = 4'b0100,
        S_TRL  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;
    t_cmd               r_cur, n_cur;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic               r_mvalid, n_mvalid;
    logic [BYTE_W-1:0]  r_mdata, n_mdata;
    logic               r_mlast, n_mlast;
    logic               r_mend, n_mend;

    logic               out_free, phase_done, in_trl;
    logic [BYTE_W-1:0]  cur_byte;
    logic [SUM_W-1:0]   word_sum;

    assign out_free = !r_mvalid || i_m_tready;
    assign in_trl   = (r_state == S_TRL);

    assign word_sum = SUM_W'(i_q_cmd.payload[7:0]) + SUM_W'(i_q_cmd.payload[15:8])
                    + SUM_W'(i_q_cmd.payload[23:16]) + SUM_W'(i_q_cmd.payload[31:24]);

    always_comb begin
        cur_byte   = '0;
        phase_done = 1'b0;
        unique case (r_state)
            S_HDR: begin
                phase_done = (r_step == STEP_W'(HDR_BYTES - 1));
                unique case (r_step)
                    4'd0:    cur_byte = SYNC_BYTE;
                    4'd1:    cur_byte = TYPE_BYTE;
                    4'd2:    cur_byte = BYTE_W'((32'(r_cur.cnt) >> LEN_HI_SHIFT)
                                                & 32'(BYTE_MASK));
                    4'd3:    cur_byte = r_cur.cnt[BYTE_W-1:0];
                    4'd4:    cur_byte = r_cur.payload[15:8];
                    4'd5:    cur_byte = r_cur.payload[7:0];
                    4'd6:    cur_byte = r_cur.payload[31:24];
                    4'd7:    cur_byte = r_cur.payload[23:16];
                    4'd8:    cur_byte = BYTE_W'(r_cur.csum >> BYTE_W);
                    4'd9:    cur_byte = r_cur.csum[BYTE_W-1:0];
                    default: cur_byte = '0;
                endcase
            end
            S_DAT, S_TRL: begin
                phase_done = (r_step == STEP_W'(DAT_BYTES - 1));
                // pair-swapped order: 15:8, 7:0, 31:24, 23:16
                unique case (r_step[1:0])
                    2'd0: cur_byte = in_trl ? r_sum[15:8]  : r_cur.payload[15:8];
                    2'd1: cur_byte = in_trl ? r_sum[7:0]   : r_cur.payload[7:0];
                    2'd2: cur_byte = in_trl ? r_sum[31:24] : r_cur.payload[31:24];
                    2'd3: cur_byte = in_trl ? r_sum[23:16] : r_cur.payload[23:16];
                endcase
            end
            default: begin
                cur_byte   = '0;
                phase_done = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_cur    = r_cur;
        n_sum    = r_sum;
        n_mvalid = r_mvalid;
        n_mdata  = r_mdata;
        n_mlast  = r_mlast;
        n_mend   = r_mend;
        o_q_pop  = 1'b0;
        if (out_free) begin
            n_mvalid = 1'b0;
            if (r_state != S_IDLE) begin
                n_mvalid = 1'b1;
                n_mdata  = cur_byte;
                n_mlast  = phase_done && (in_trl || !r_cur.trail);
                n_mend   = phase_done && in_trl;
                n_step   = r_step + STEP_W'(1);
            end
            if (r_state != S_IDLE && phase_done && !in_trl && r_cur.trail) begin
                n_state = S_TRL;
                n_step  = '0;
            end else if (r_state == S_IDLE || phase_done) begin
                n_state = S_IDLE;
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cur   = i_q_cmd;
                    n_step  = '0;
                    if (i_q_cmd.kind == K_HDR) begin
                        n_state = S_HDR;
                        n_sum   = '0;
                    end else begin
                        n_state = S_DAT;
                        n_sum   = r_sum + word_sum;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= '0;
            r_sum    <= '0;
            r_mvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_sum    <= n_sum;
            r_mvalid <= n_mvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_mdata <= n_mdata;
        r_mlast <= n_mlast;
        r_mend  <= n_mend;
    end

    assign o_m_tvalid = r_mvalid;
    assign o_m_tdata  = r_mdata;
    assign o_m_tlast  = r_mlast;
    assign o_m_tuser  = r_mend;

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("packet end beat without tlast");

    a_word_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DAT || r_state == S_TRL) |-> (r_step < STEP_W'(DAT_BYTES)))
        else $error("data or trailer step out of range");

endmodule

### rtl/boot_data_packet_framer.sv
// ----------------------------------------------------------------------------
// boot_data_packet_framer: bootloader data packet byte framer
// Turns start and data beats into the serial byte stream of one data packet.
// ----------------------------------------------------------------------------
// A start beat (tuser = 0) opens a packet and produces ten header bytes:
// 0x30, 0x01, two length bytes, the address as bits 15:8, 7:0, 31:24, 23:16,
// and an 11-bit sum of header bytes two to seven, high byte first. Counts above
// 256 are clamped. Each data beat (tuser = 1) produces four bytes in the order
// 15:8, 7:0, 31:24, 23:16 and adds them to a 32-bit running sum; after the
// last word, or right after the header for a count of zero, the sum follows in
// the same byte order and the packet closes. Data beats with no packet open
// are dropped without output, and a start beat during an open packet abandons
// it with no trailer. Output runs one byte per cycle while tready is high and
// commands are queued, so a data beat yields four bytes (eight when it carries
// the trailer) and a start beat ten (fourteen for an empty packet); that rate
// is set by the byte serializer in the back end. A two-entry command queue
// sits between the input classifier and the serializer, so input beats keep
// flowing while bytes drain. The output register holds each byte steady until
// tready takes it; the serializer waits meanwhile and loads the next byte at
// the edge the current one leaves. tlast marks the final byte caused by one
// input beat; tuser marks the final trailer byte of the packet.
// ----------------------------------------------------------------------------
module boot_data_packet_framer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // dest_address [31:0], word_count [40:32], data_word [72:41], zero pad
    input  logic [bdpf_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // command: 0 start packet, 1 data word
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // out_byte [7:0]
    output logic [bdpf_pkg::BYTE_W-1:0]     o_m_tdata,
    // run_last
    output logic                            o_m_tlast,
    // packet_end
    output logic                            o_m_tuser
);
    import bdpf_pkg::*;

    logic q_full, q_push, q_valid, q_pop;
    t_cmd q_in_cmd, q_out_cmd;

    // front end: packet tracking and command build
    bdpf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (q_in_cmd)
    );

    // short queue decoupling the two sides
    bdpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    // back end: one byte per beat, running sum, trailer
    bdpf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_cmd    (q_out_cmd),
        .o_q_pop    (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
